// ----- sv/ita_pkg.sv -----
// Shared types, codes and helpers for the integer to ASCII converter.
// No dependencies; every other file in sv/ imports this package.
package ita_pkg;

	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned HALF_W    = 32;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned STACK_D   = 16;
	localparam int unsigned COUNT_W   = $clog2(STACK_D + 1);
	localparam int unsigned BITCNT_W  = $clog2(HALF_W);

	localparam logic [2:0] OP_SDEC = 3'd0;
	localparam logic [2:0] OP_UDEC = 3'd1;
	localparam logic [2:0] OP_OCT  = 3'd2;
	localparam logic [2:0] OP_HEX  = 3'd3;
	localparam logic [2:0] OP_CHAR = 3'd4;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

	localparam logic [4:0] DEC_BASE = 5'd10;

	typedef enum logic [1:0] {
		RDX_DEC = 2'd0,
		RDX_OCT = 2'd1,
		RDX_HEX = 2'd2
	} radix_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [VALUE_W-1:0] value;
	} ita_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last;
	} ita_out_t;

	// Status from the digit extractor to the sequencer.
	typedef struct packed {
		logic               done;
		logic               zero;
		logic [DIGIT_W-1:0] digit;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d > 4'd9) begin
			return ext - 8'd10 + CH_UPPER_A;
		end
		return ext + CH_ZERO;
	endfunction

endpackage

// ----- sv/ita_digit_div.sv -----
// Digit extractor: one decimal digit by bit-serial restoring division,
// or one octal/hex digit per cycle while go is held, by shifting. Depends on ita_pkg.
module ita_digit_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [ita_pkg::VALUE_W-1:0]   load_value,
	input  ita_pkg::radix_t               load_radix,
	input  logic                          go,
	output ita_pkg::div_stat_t            stat
);
	import ita_pkg::*;

	logic [VALUE_W-1:0]  val_q;
	radix_t              radix_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [DIGIT_W-1:0]  dig_q;
	logic [BITCNT_W-1:0] cnt_q;
	logic                run_q;
	logic                done_q;

	logic [4:0]          trial;
	logic                ge;
	logic [4:0]          diff;
	logic [DIGIT_W-1:0]  rem_n;

	assign trial = {rem_q, val_q[HALF_W-1]};
	assign ge    = trial >= DEC_BASE;
	assign diff  = trial - DEC_BASE;
	assign rem_n = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= '0;
				if (radix_q == RDX_DEC) begin
					run_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BITCNT_W'(HALF_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q   <= load_value;
			radix_q <= load_radix;
		end else if (go) begin
			case (radix_q)
				RDX_HEX: begin
					dig_q <= val_q[3:0];
					val_q <= val_q >> 4;
				end
				RDX_OCT: begin
					dig_q <= {1'b0, val_q[2:0]};
					val_q <= val_q >> 3;
				end
				default: begin
					rem_q <= '0;
				end
			endcase
		end else if (run_q) begin
			// shift the next dividend bit into the remainder, quotient bit in at the bottom
			rem_q <= rem_n;
			val_q <= {val_q[VALUE_W-1:HALF_W], val_q[HALF_W-2:0], ge};
			if (cnt_q == BITCNT_W'(HALF_W - 1)) begin
				dig_q <= rem_n;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.zero  = (val_q == '0);
	assign stat.digit = dig_q;

endmodule

// ----- sv/ita_digit_stack.sv -----
// Last-in first-out shift line for digit codes, least significant pushed first.
// Depends on ita_pkg.
module ita_digit_stack (
	input  logic                        clk,
	input  logic                        push,
	input  logic                        pop,
	input  logic [ita_pkg::DIGIT_W-1:0] push_digit,
	output logic [ita_pkg::DIGIT_W-1:0] top_digit
);
	import ita_pkg::*;

	logic [DIGIT_W-1:0] stk_q [STACK_D];

	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= push_digit;
			for (int i = 1; i < STACK_D; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < STACK_D - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	assign top_digit = stk_q[0];

endmodule

// ----- sv/integer_to_ascii_radix.sv -----
// Top level of the integer to ASCII converter: command sequencer and result register.
// Depends on ita_pkg, ita_digit_div and ita_digit_stack.
//
//   channel  signals               transfer when
//   -------  --------------------  -------------------------------
//   command  start, busy, req      rising edge with start & !busy
//   result   strobe, result        rising edge ending a strobe cycle
//
// A decimal digit takes 32 restoring-division steps over the low word plus
// handoff; an octal or hex digit takes one shift and one push. After the
// digits are found, one character leaves per cycle, a leading minus first.
// Raw character mode answers in the cycle after the transfer and stays idle.
// Reset clears the sequencer and the strobe. The receiver cannot stall;
// results come out as they are formed.
module integer_to_ascii_radix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ita_pkg::ita_in_t req,
	output logic             strobe,
	output ita_pkg::ita_out_t result
);
	import ita_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_SIGN = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] count_q;
	logic               neg_q;
	logic               go_q;
	logic               strobe_q;
	ita_out_t           out_q;

	logic               accept;
	logic               conv_op;
	logic               load;
	logic [VALUE_W-1:0] load_value;
	radix_t             load_radix;
	logic [HALF_W-1:0]  low32;
	logic [HALF_W-1:0]  mag;
	logic               push;
	logic               pop;
	logic [COUNT_W-1:0] count_inc;
	logic               finish;
	logic [DIGIT_W-1:0] top_digit;
	div_stat_t          dstat;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign conv_op = (req.opcode == OP_SDEC) || (req.opcode == OP_UDEC) ||
	                 (req.opcode == OP_OCT)  || (req.opcode == OP_HEX);
	assign load    = accept && conv_op;

	// Decode the mode into a starting value; negate a negative signed value, which also
	// turns the signed minimum into its unsigned magnitude.
	assign low32 = req.value[HALF_W-1:0];
	assign mag   = HALF_W'(0) - low32;

	always_comb begin
		load_value = {{(VALUE_W-HALF_W){1'b0}}, low32};
		load_radix = RDX_DEC;
		case (req.opcode)
			OP_SDEC: begin
				if (low32[HALF_W-1]) begin
					load_value = {{(VALUE_W-HALF_W){1'b0}}, mag};
				end
			end
			OP_OCT: begin
				load_radix = RDX_OCT;
			end
			OP_HEX: begin
				load_value = req.value;
				load_radix = RDX_HEX;
			end
			default: begin
			end
		endcase
	end

	assign push      = (state_q == S_DIV) && dstat.done;
	assign pop       = (state_q == S_EMIT);
	assign count_inc = count_q + 1'b1;
	// stop on a zero quotient or a full digit stack
	assign finish    = dstat.zero || (count_inc == COUNT_W'(STACK_D));

	ita_digit_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_value (load_value),
		.load_radix (load_radix),
		.go         (go_q),
		.stat       (dstat)
	);

	ita_digit_stack u_stack (
		.clk        (clk),
		.push       (push),
		.pop        (pop),
		.push_digit (dstat.digit),
		.top_digit  (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			go_q     <= 1'b0;
			strobe_q <= 1'b0;
			neg_q    <= 1'b0;
		end else begin
			go_q     <= 1'b0;
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && req.opcode == OP_CHAR) begin
						strobe_q <= 1'b1;
					end else if (load) begin
						neg_q   <= (req.opcode == OP_SDEC) && low32[HALF_W-1];
						count_q <= '0;
						go_q    <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dstat.done) begin
						count_q <= count_inc;
						if (finish) begin
							state_q <= neg_q ? S_SIGN : S_EMIT;
						end else begin
							go_q <= 1'b1;
						end
					end
				end
				S_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					count_q  <= count_q - 1'b1;
					if (count_q == COUNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload, held only in S_DIV; strobe marks the valid cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				out_q.out_char <= req.value[CHAR_W-1:0];
				out_q.last     <= 1'b1;
			end
			S_SIGN: begin
				out_q.out_char <= CH_MINUS;
				out_q.last     <= 1'b0;
			end
			S_EMIT: begin
				out_q.out_char <= digit_to_ascii(top_digit);
				out_q.last     <= (count_q == COUNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	assign strobe = strobe_q;
	assign result = out_q;

endmodule
